/* hw/rtl/vector_terminal_address_encoder_defines.svh */
// ----------------------------------------------------------------------------
// vector terminal address encoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TERMINAL_ADDRESS_ENCODER_DEFINES_SVH
`define VECTOR_TERMINAL_ADDRESS_ENCODER_DEFINES_SVH

// same-cycle implication, reset masked
`define VTAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define VTAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/vtae_pkg.sv */
// ----------------------------------------------------------------------------
// vtae_pkg
// Shared types and constants of the vector terminal address encoder.
// ----------------------------------------------------------------------------
package vtae_pkg;

	// command codes
	typedef enum logic [1:0] {
		OP_DRAW   = 2'd0,
		OP_CHAR   = 2'd1,
		OP_FORGET = 2'd2
	} opcode_t;

	// control characters of the terminal link
	localparam logic [7:0] CodeGs = 8'h1D;
	localparam logic [7:0] CodeUs = 8'h1F;
	localparam logic [7:0] SentNone = 8'hFF;

	// address byte offsets
	localparam logic [7:0] HighBase  = 8'd32;
	localparam logic [7:0] LowYBase  = 8'd96;
	localparam logic [7:0] LowXBase  = 8'd64;
	localparam int unsigned CoordMax = 1023;
	localparam int unsigned AxisW    = 10;

	// longest byte sequence of one command and its count width
	localparam int unsigned MaxBytes = 9;
	localparam int unsigned CntW     = $clog2(MaxBytes + 1);

	typedef logic [CntW-1:0] cnt_t;

	// four bytes of one terminal address
	typedef struct packed {
		logic [7:0] hy;
		logic [7:0] ly;
		logic [7:0] hx;
		logic [7:0] lx;
	} addr_bytes_t;

	// address bytes last sent on the link
	typedef struct packed {
		logic [7:0] hy;
		logic [7:0] ly;
		logic [7:0] hx;
	} sent_t;

	// byte sequence of one command, word 0 goes out first
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		cnt_t                     count;
	} byte_list_t;

	// split a clamped point into terminal address bytes
	function automatic addr_bytes_t addr_bytes(input logic [AxisW-1:0] x,
			input logic [AxisW-1:0] y);
		addr_bytes_t a;
		a.hy = 8'(y[AxisW-1:5]) + HighBase;
		a.ly = 8'(y[4:0]) + LowYBase;
		a.hx = 8'(x[AxisW-1:5]) + HighBase;
		a.lx = 8'(x[4:0]) + LowXBase;
		return a;
	endfunction

endpackage

/* hw/rtl/vector_terminal_address_encoder.sv */
// ----------------------------------------------------------------------------
// vector_terminal_address_encoder
// Turns draw, char and forget commands into the address byte stream of a
// vector graphics terminal, leaving out address bytes that have not changed.
// ----------------------------------------------------------------------------
//   channel   handshake             payload
//   in        in_valid / in_ready   opcode, from_x, from_y, to_x, to_y, char_code
//   out       out_valid / out_ready out_byte, last_byte
//
// A command is taken into the input register, encoded combinationally into its
// byte sequence and loaded into the output shift register, which sends one
// word a cycle while out_ready is high: a draw or char command has 1 to 9
// bytes, a forget or unused code has none and sends nothing. The output register sets
// the rate. A new command is taken while the previous one still shifts out.
// Reset clears the pen position, the sent address bytes and both registers.
// A stall on out holds the current word and backs up into in_ready.
module vector_terminal_address_encoder #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic signed [COORD_WIDTH-1:0] from_x,
	input  logic signed [COORD_WIDTH-1:0] from_y,
	input  logic signed [COORD_WIDTH-1:0] to_x,
	input  logic signed [COORD_WIDTH-1:0] to_y,
	input  logic [7:0]                    char_code,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_byte,
	output logic                          last_byte
);

	`include "vector_terminal_address_encoder_defines.svh"

	logic                   valid_s1;
	logic [1:0]             opcode_s1;
	logic [COORD_WIDTH-1:0] from_x_s1;
	logic [COORD_WIDTH-1:0] from_y_s1;
	logic [COORD_WIDTH-1:0] to_x_s1;
	logic [COORD_WIDTH-1:0] to_y_s1;
	logic [7:0]             char_code_s1;

	logic [COORD_WIDTH-1:0] last_x_q;
	logic [COORD_WIDTH-1:0] last_y_q;
	logic                   pos_valid_q;
	vtae_pkg::sent_t        sent_q;

	vtae_pkg::byte_list_t   list;
	vtae_pkg::sent_t        next_sent;
	logic                   ser_free;
	logic                   load_s1;
	logic                   in_fire;

	// command leaves the input register when its bytes fit or it has none
	assign load_s1  = valid_s1 && (ser_free || list.count == '0);
	assign in_ready = !valid_s1 || load_s1;
	assign in_fire  = in_valid && in_ready;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			opcode_s1    <= opcode;
			from_x_s1    <= from_x;
			from_y_s1    <= from_y;
			to_x_s1      <= to_x;
			to_y_s1      <= to_y;
			char_code_s1 <= char_code;
		end
	end

	// pen position and link address state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= '1;
			last_y_q    <= '1;
			pos_valid_q <= 1'b0;
			sent_q      <= {vtae_pkg::SentNone, vtae_pkg::SentNone, vtae_pkg::SentNone};
		end else if (load_s1) begin
			sent_q <= next_sent;
			case (opcode_s1)
				vtae_pkg::OP_DRAW: begin
					last_x_q    <= to_x_s1;
					last_y_q    <= to_y_s1;
					pos_valid_q <= 1'b1;
				end
				vtae_pkg::OP_CHAR, vtae_pkg::OP_FORGET: begin
					pos_valid_q <= 1'b0;
				end
				default: begin
					pos_valid_q <= pos_valid_q;
				end
			endcase
		end
	end

	// byte sequence of the held command
	vtae_encoder #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_encoder (
		.opcode    (opcode_s1),
		.from_x    (from_x_s1),
		.from_y    (from_y_s1),
		.to_x      (to_x_s1),
		.to_y      (to_y_s1),
		.char_code (char_code_s1),
		.last_x    (last_x_q),
		.last_y    (last_y_q),
		.pos_valid (pos_valid_q),
		.sent      (sent_q),
		.list      (list),
		.next_sent (next_sent)
	);

	// output shift register
	vtae_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_s1 && list.count != '0),
		.list_in   (list),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.free      (ser_free)
	);

	// checks
	`VTAE_ASSERT_NEXT(a_word_follows, clk, arst_n, out_valid && out_ready && !last_byte, out_valid, "command cut short before its last word")
	`VTAE_ASSERT_NEXT(a_forget_clears, clk, arst_n, load_s1 && opcode_s1 == vtae_pkg::OP_FORGET, !pos_valid_q, "forget left a valid position")
	`VTAE_ASSERT_NEXT(a_draw_stores, clk, arst_n, load_s1 && opcode_s1 == vtae_pkg::OP_DRAW, pos_valid_q && last_x_q == $past(to_x_s1) && last_y_q == $past(to_y_s1), "draw end point not stored")
	`VTAE_ASSERT_NOW(a_sent_hy_range, clk, arst_n, 1'b1, sent_q.hy == vtae_pkg::SentNone || sent_q.hy[7:5] == 3'b001, "sent hi-Y byte out of range")

endmodule

/* hw/rtl/vtae_encoder.sv */
// ----------------------------------------------------------------------------
// vtae_encoder
// Builds the byte sequence of one command and the address bytes sent after it.
// ----------------------------------------------------------------------------
module vtae_encoder #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic [1:0]              opcode,
	input  logic [COORD_WIDTH-1:0]  from_x,
	input  logic [COORD_WIDTH-1:0]  from_y,
	input  logic [COORD_WIDTH-1:0]  to_x,
	input  logic [COORD_WIDTH-1:0]  to_y,
	input  logic [7:0]              char_code,
	input  logic [COORD_WIDTH-1:0]  last_x,
	input  logic [COORD_WIDTH-1:0]  last_y,
	input  logic                    pos_valid,
	input  vtae_pkg::sent_t         sent,
	output vtae_pkg::byte_list_t    list,
	output vtae_pkg::sent_t         next_sent
);

	// clamp a raw coordinate to the screen range
	function automatic logic [vtae_pkg::AxisW-1:0] clamp(input logic [COORD_WIDTH-1:0] v);
		logic [vtae_pkg::AxisW-1:0] r;
		if (v[COORD_WIDTH-1]) begin
			r = '0;
		end else if (v > COORD_WIDTH'(vtae_pkg::CoordMax)) begin
			r = vtae_pkg::AxisW'(vtae_pkg::CoordMax);
		end else begin
			r = v[vtae_pkg::AxisW-1:0];
		end
		return r;
	endfunction

	logic                  is_draw;
	logic                  is_char;
	logic                  repos;
	vtae_pkg::addr_bytes_t start_a;
	vtae_pkg::addr_bytes_t end_a;
	vtae_pkg::sent_t       cur;
	vtae_pkg::cnt_t        n;

	// command decode and reposition test
	assign is_draw = (opcode == vtae_pkg::OP_DRAW);
	assign is_char = (opcode == vtae_pkg::OP_CHAR);
	assign repos   = (is_draw || is_char) &&
		(!pos_valid || from_x != last_x || from_y != last_y);

	assign start_a = vtae_pkg::addr_bytes(clamp(from_x), clamp(from_y));
	assign end_a   = vtae_pkg::addr_bytes(clamp(to_x), clamp(to_y));

	// bytes on the link before the end address
	assign cur = repos ? vtae_pkg::sent_t'({start_a.hy, start_a.ly, start_a.hx}) : sent;

	// after a draw the link holds the end address, after a reposition the start
	always_comb begin
		if (is_draw) begin
			next_sent = {end_a.hy, end_a.ly, end_a.hx};
		end else begin
			next_sent = cur;
		end
	end

	// append the bytes of the command in link order
	always_comb begin
		list = '0;
		n    = '0;
		if (is_draw || is_char) begin
			if (repos) begin
				list.bytes[n] = vtae_pkg::CodeGs;
				n = n + vtae_pkg::cnt_t'(1);
				list.bytes[n] = start_a.hy;
				n = n + vtae_pkg::cnt_t'(1);
				list.bytes[n] = start_a.ly;
				n = n + vtae_pkg::cnt_t'(1);
				list.bytes[n] = start_a.hx;
				n = n + vtae_pkg::cnt_t'(1);
				list.bytes[n] = start_a.lx;
				n = n + vtae_pkg::cnt_t'(1);
			end
			if (is_draw) begin
				if (end_a.hy != cur.hy) begin
					list.bytes[n] = end_a.hy;
					n = n + vtae_pkg::cnt_t'(1);
				end
				if (end_a.ly != cur.ly || end_a.hx != cur.hx) begin
					list.bytes[n] = end_a.ly;
					n = n + vtae_pkg::cnt_t'(1);
					if (end_a.hx != cur.hx) begin
						list.bytes[n] = end_a.hx;
						n = n + vtae_pkg::cnt_t'(1);
					end
				end
				list.bytes[n] = end_a.lx;
				n = n + vtae_pkg::cnt_t'(1);
			end else begin
				list.bytes[n] = vtae_pkg::CodeUs;
				n = n + vtae_pkg::cnt_t'(1);
				list.bytes[n] = char_code;
				n = n + vtae_pkg::cnt_t'(1);
			end
		end
		list.count = n;
	end

endmodule

/* hw/rtl/vtae_serializer.sv */
// ----------------------------------------------------------------------------
// vtae_serializer
// Result register shifting a command's bytes one word a cycle while out_ready.
// ----------------------------------------------------------------------------
module vtae_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  vtae_pkg::byte_list_t list_in,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 last_byte,
	output logic                 free
);

	logic [vtae_pkg::MaxBytes-1:0][7:0] bytes_q;
	vtae_pkg::cnt_t                     cnt_q;
	logic                               fire;

	assign out_valid = (cnt_q != '0);
	assign out_byte  = bytes_q[0];
	assign last_byte = (cnt_q == vtae_pkg::cnt_t'(1));
	assign fire      = out_valid && out_ready;
	// empty, or the last word leaves in this cycle
	assign free      = !out_valid || (last_byte && out_ready);

	// remaining word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= list_in.count;
		end else if (fire) begin
			cnt_q <= cnt_q - vtae_pkg::cnt_t'(1);
		end
	end

	// byte shift line
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= list_in.bytes;
		end else if (fire) begin
			bytes_q <= {8'h00, bytes_q[vtae_pkg::MaxBytes-1:1]};
		end
	end

endmodule
